[rtl/core/sem_pkg.sv]
// Shared types, constants and register codes of the Sobel edge magnitude unit.
`timescale 1ns / 1ps

package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CFG_DATA_W      = 12;
  localparam int unsigned CFG_IDX_W       = 2;

  // Q0.16 luma weights and the rounding offset of the weighted sum.
  localparam logic [15:0] W_RED      = 16'd19589;
  localparam logic [15:0] W_GREEN    = 16'd38470;
  localparam logic [15:0] W_BLUE     = 16'd7471;
  localparam logic [15:0] GRAY_ROUND = 16'd32768;

  // Smallest image side and the sum of squares from which the root saturates.
  localparam int unsigned MIN_DIM = 3;
  localparam logic [20:0] SAT_SUM = 21'd65281;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic        COLOR_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_COLOR_MODE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] image_width;
    logic [11:0] image_height;
    logic        color_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  magnitude;
    logic [11:0] center_row;
    logic [9:0]  center_column;
    logic        final_result;
  } result_t;

  // One gradient pair on its way from the window logic to the root unit.
  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [11:0]        center_row;
    logic [9:0]         center_column;
    logic               final_result;
  } grad_t;

endpackage

[rtl/core/sem_fifo.sv]
// Small register queue used between the pipeline parts and at the result side.
`timescale 1ns / 1ps

module sem_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import sem_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/sem_front.sv]
// Front part: gray conversion, line buffers, 3x3 window and Sobel gradients.
`timescale 1ns / 1ps

module sem_front #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  sem_pkg::pixel_t pixel_i,
  input  sem_pkg::cfg_t   cfg_i,
  output logic            grad_valid_o,
  input  logic            grad_ready_i,
  output sem_pkg::grad_t  grad_o
);
  import sem_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_WORK = 2'b10
  } front_state_e;

  front_state_e     state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [11:0]      row_q, row_d;
  logic [47:0]      window_q;

  // Both line buffers share one memory word: upper row low, middle row high.
  logic [15:0]      line_mem [MAX_WIDTH];
  logic [15:0]      line_rd_q;
  logic [23:0]      prod_r_q, prod_g_q, prod_b_q;
  logic [7:0]       red_q;

  logic             accept;
  logic             step;
  logic             has_result;
  logic [24:0]      prod_sum;
  logic [8:0]       gray_scaled;
  logic [7:0]       gray;
  logic [7:0]       top_px, mid_px;
  logic [7:0]       tl, ml, bl, tc, bc;
  logic [9:0]       pos_x, neg_x, pos_y, neg_y;
  logic [CMP_W-1:0] width_in, width_eff, col_ext, col_inc;
  logic [11:0]      height_eff;
  logic [12:0]      row_inc;
  logic             col_wrap, row_wrap;
  logic [COL_W-1:0] col_dec;

  assign full_o = (state_q != F_IDLE);
  assign accept = push_i && (state_q == F_IDLE);

  always_comb begin
    prod_sum    = 25'(prod_r_q) + 25'(prod_g_q) + 25'(prod_b_q) + 25'(GRAY_ROUND);
    gray_scaled = prod_sum[24:16];
    if (!cfg_i.color_mode) begin
      gray = red_q;
    end else if (gray_scaled > 9'd255) begin
      gray = 8'hff;
    end else begin
      gray = gray_scaled[7:0];
    end
  end

  assign top_px = line_rd_q[7:0];
  assign mid_px = line_rd_q[15:8];
  assign tc     = window_q[7:0];
  assign bc     = window_q[23:16];
  assign tl     = window_q[31:24];
  assign ml     = window_q[39:32];
  assign bl     = window_q[47:40];

  assign pos_x = {2'b0, top_px} + {1'b0, mid_px, 1'b0} + {2'b0, gray};
  assign neg_x = {2'b0, tl} + {1'b0, ml, 1'b0} + {2'b0, bl};
  assign pos_y = {2'b0, bl} + {1'b0, bc, 1'b0} + {2'b0, gray};
  assign neg_y = {2'b0, tl} + {1'b0, tc, 1'b0} + {2'b0, top_px};

  always_comb begin
    width_in = CMP_W'(cfg_i.image_width);
    if (width_in < CMP_W'(MIN_DIM)) begin
      width_eff = CMP_W'(MIN_DIM);
    end else if (width_in > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_in;
    end
    if (cfg_i.image_height < 12'(MIN_DIM)) begin
      height_eff = 12'(MIN_DIM);
    end else begin
      height_eff = cfg_i.image_height;
    end
  end

  assign col_ext  = CMP_W'(col_q);
  assign col_inc  = col_ext + 1'b1;
  assign col_wrap = (col_inc >= width_eff);
  assign row_inc  = {1'b0, row_q} + 13'd1;
  assign row_wrap = (row_inc >= {1'b0, height_eff});
  assign col_d    = col_wrap ? '0 : col_inc[COL_W-1:0];
  assign row_d    = !col_wrap ? row_q : (row_wrap ? '0 : row_inc[11:0]);
  assign col_dec  = col_q - COL_W'(1);

  assign has_result = (row_q >= 12'd2) && (col_q >= COL_W'(2));
  assign step       = (state_q == F_WORK) && (!has_result || grad_ready_i);

  assign grad_valid_o          = (state_q == F_WORK) && has_result;
  assign grad_o.gx             = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
  assign grad_o.gy             = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
  assign grad_o.center_row     = row_q - 12'd1;
  assign grad_o.center_column  = 10'(col_dec);
  assign grad_o.final_result   = (row_q == height_eff - 12'd1) &&
                                 (col_ext == width_eff - CMP_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_WORK;
        end
      end
      F_WORK: begin
        if (step) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      window_q <= '0;
    end else begin
      state_q <= state_d;
      if (step) begin
        col_q    <= col_d;
        row_q    <= row_d;
        window_q <= {window_q[23:0], gray, mid_px, top_px};
      end
    end
  end

  // The line memory is read when a word is taken and written when it retires.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_r_q  <= 24'(pixel_i.red) * 24'(W_RED);
      prod_g_q  <= 24'(pixel_i.green) * 24'(W_GREEN);
      prod_b_q  <= 24'(pixel_i.blue) * 24'(W_BLUE);
      red_q     <= pixel_i.red;
      line_rd_q <= line_mem[col_q];
    end
    if (step) begin
      line_mem[col_q] <= {gray, mid_px};
    end
  end

endmodule

[rtl/core/sem_back.sv]
// Back part: sum of squares and rounded integer square root, one bit per cycle.
`timescale 1ns / 1ps

module sem_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             grad_valid_i,
  output logic             grad_pop_o,
  input  sem_pkg::grad_t   grad_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sem_pkg::result_t res_o
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_SQUARE = 4'b0010,
    B_ROOT   = 4'b0100,
    B_ROUND  = 4'b1000
  } back_state_e;

  back_state_e        state_q, state_d;
  grad_t              grad_q;
  logic [20:0]        sum_q;
  logic [7:0]         root_q;
  logic [7:0]         bit_q;

  logic signed [21:0] sq_x, sq_y;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;
  logic [15:0]        root_sq;
  logic [16:0]        round_bound;
  logic               round_up;
  logic               saturate;

  assign sq_x = grad_q.gx * grad_q.gx;
  assign sq_y = grad_q.gy * grad_q.gy;

  assign trial    = root_q | bit_q;
  assign trial_sq = {8'b0, trial} * {8'b0, trial};

  // Round to nearest: step up when the sum lies above r*r + r.
  assign root_sq     = {8'b0, root_q} * {8'b0, root_q};
  assign round_bound = {1'b0, root_sq} + 17'(root_q);
  assign round_up    = ({4'b0, round_bound} < sum_q);
  assign saturate    = (sum_q >= SAT_SUM);

  assign grad_pop_o          = (state_q == B_IDLE) && grad_valid_i;
  assign res_valid_o         = (state_q == B_ROUND);
  assign res_o.magnitude     = saturate ? 8'hff : root_q + {7'b0, round_up};
  assign res_o.center_row    = grad_q.center_row;
  assign res_o.center_column = grad_q.center_column;
  assign res_o.final_result  = grad_q.final_result;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (grad_valid_i) begin
          state_d = B_SQUARE;
        end
      end
      B_SQUARE: state_d = B_ROOT;
      B_ROOT: begin
        if (bit_q[0]) begin
          state_d = B_ROUND;
        end
      end
      B_ROUND: begin
        if (res_ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      root_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_SQUARE) begin
        root_q <= '0;
        bit_q  <= 8'h80;
      end else if (state_q == B_ROOT) begin
        if ({5'b0, trial_sq} <= sum_q) begin
          root_q <= trial;
        end
        bit_q <= bit_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grad_pop_o) begin
      grad_q <= grad_i;
    end
    if (state_q == B_SQUARE) begin
      sum_q <= {1'b0, sq_x[19:0]} + {1'b0, sq_y[19:0]};
    end
  end

endmodule

[rtl/core/sobel_edge_magnitude_unit.sv]
// Top level of the Sobel edge magnitude unit: configuration, queues and both parts.
// Path: a word goes through the front, gradient queue, root unit and result queue.
// Flow: the front takes a new pixel only after the last has left its work state; the
// root unit's steps (pop, square, 8 root bits, rounding) set the sustained rate.
// Reset: asynchronous, active low; clears counters, window and queues and loads the
// size and mode registers with their defaults; the line buffer memory is not cleared.
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit #(
  parameter int unsigned MAX_WIDTH   = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  sem_pkg::pixel_t                   pixel_i,
  output logic                              empty,
  input  logic                              pop,
  output sem_pkg::result_t                  result_o,
  input  logic                              cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sem_pkg::*;

  cfg_t    cfg_q;
  grad_t   grad_front;
  grad_t   grad_queued;
  logic    grad_valid;
  logic    grad_full;
  logic    grad_empty;
  logic    grad_pop;
  result_t res_back;
  logic    res_valid;
  logic    res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
      cfg_q.color_mode   <= COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[11:0];
        CFG_COLOR_MODE:   cfg_q.color_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .pixel_i      (pixel_i),
    .cfg_i        (cfg_q),
    .grad_valid_o (grad_valid),
    .grad_ready_i (!grad_full),
    .grad_o       (grad_front)
  );

  sem_fifo #(
    .WIDTH ($bits(grad_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_grad_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grad_valid),
    .data_i  (grad_front),
    .full_o  (grad_full),
    .pop_i   (grad_pop),
    .data_o  (grad_queued),
    .empty_o (grad_empty)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grad_valid_i (!grad_empty),
    .grad_pop_o   (grad_pop),
    .grad_i       (grad_queued),
    .res_valid_o  (res_valid),
    .res_ready_i  (!res_full),
    .res_o        (res_back)
  );

  sem_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_back),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // A taken word keeps the front busy for at least the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front accepted a word without going busy");

  // A gradient held back by a full queue must still be offered next cycle.
  a_grad_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grad_valid && grad_full) |=> grad_valid)
    else $error("stalled gradient was dropped by the front");

  // Results belong to interior pixels only, so their row is never the top one.
  a_interior_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.center_row != '0))
    else $error("result reported for a border row");

endmodule
